/* sv/keq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event queue package
// Shared types and key code constants for the key event queue.
// ----------------------------------------------------------------------------
package keq_pkg;

    localparam logic [7:0] KC_ESC    = 8'h1b;
    localparam logic [7:0] KC_RETURN = 8'h0d;
    localparam logic [7:0] KC_USE    = 8'ha2;
    localparam logic [7:0] KC_SHOOT  = 8'ha3;
    localparam logic [7:0] KC_UP     = 8'had;
    localparam logic [7:0] KC_DOWN   = 8'haf;
    localparam logic [7:0] KC_LEFT   = 8'hac;
    localparam logic [7:0] KC_RIGHT  = 8'hae;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_GET  = 1'b1;

    localparam logic [15:0] DELAY_RESET = 16'd100;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SCHED,
        ST_EXP_RD,
        ST_EXP_CHK,
        ST_POP_RD,
        ST_POP_WAIT
    } t_state;

    // Map a received byte to a key code.
    function automatic logic [7:0] map_char(input logic [7:0] c);
        logic [7:0] k;
        k = c;
        unique case (c)
            8'h71, 8'h51: k = KC_ESC;
            8'h0a, 8'h0d: k = KC_RETURN;
            8'h20:        k = KC_USE;
            8'h6a, 8'h4a: k = KC_SHOOT;
            8'h77, 8'h57: k = KC_UP;
            8'h73, 8'h53: k = KC_DOWN;
            8'h61, 8'h41: k = KC_LEFT;
            8'h64, 8'h44: k = KC_RIGHT;
            default:      k = c;
        endcase
        return k;
    endfunction

endpackage

/* sv/keq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module keq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/key_event_queue_auto_release.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key event queue with automatic release
// Turns characters into press events with timed releases; serves get beats.
// ----------------------------------------------------------------------------
// Channel | Signals                                     | Direction
// in      | i_valid/o_ready, req_type, char_code, time  | sink
// out     | o_valid/i_ready, event_valid/pressed/key    | source
// cfg     | i_cfg_we, i_cfg_wdata                       | sink
// Character beat: a read and a check per slot searched, then the schedule
// write; a new beat is accepted only once the block is back in idle.
// Get beat: a read and a check per timer, then the pop; the result is
// registered at the end of the pop.
// Reset is synchronous; no clearing pass is needed. A get beat waits in the
// pop step only while the previous result is still held in the output.
// ----------------------------------------------------------------------------
module key_event_queue_auto_release #(
    parameter int TIMER_SLOTS = 32,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [31:0] i_time_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_event_valid,
    output logic        o_event_pressed,
    output logic [7:0]  o_event_key,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    localparam int TW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int TCW = $clog2(TIMER_SLOTS + 1);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [TCW-1:0] SLOTS_C = TCW'(TIMER_SLOTS);
    localparam logic [QCW-1:0] DEPTH_C = QCW'(QUEUE_DEPTH);

    keq_pkg::t_state r_state, n_state;
    logic [15:0]    r_delay;
    logic [TCW-1:0] r_tcount, n_tcount;
    logic [TCW-1:0] r_idx, n_idx;     // read index
    logic [TCW-1:0] r_wr, n_wr;       // compacted write index
    logic [QW-1:0]  r_wptr, n_wptr, r_rptr, n_rptr;
    logic [QCW-1:0] r_fill, n_fill;
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_key;
    logic [31:0]    r_time;
    logic           r_ev_valid, r_ev_pr;
    logic [7:0]     r_ev_key;
    logic           n_ev_valid, n_ev_pr;
    logic [7:0]     n_ev_key;

    logic           t_we;
    logic [TW-1:0]  t_waddr, t_raddr;
    logic [39:0]    t_wdata, t_rdata;
    logic           q_we;
    logic [8:0]     q_wdata, q_rdata;

    logic [31:0]    diff;
    logic           fifo_ok;

    keq_ram #(.WIDTH(40), .DEPTH(TIMER_SLOTS)) u_timer_ram (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata)
    );

    keq_ram #(.WIDTH(9), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(r_wptr), .i_wdata(q_wdata),
        .i_raddr(r_rptr), .o_rdata(q_rdata)
    );

    assign diff    = r_time - t_rdata[31:0];
    assign fifo_ok = (r_fill < DEPTH_C);
    assign t_raddr = r_idx[TW-1:0];

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= keq_pkg::DELAY_RESET;
        end else if (i_cfg_we) begin
            r_delay <= i_cfg_wdata;
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_key  <= keq_pkg::map_char(i_char_code);
            r_time <= i_time_ms;
        end
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= keq_pkg::ST_IDLE;
            r_tcount    <= '0;
            r_idx       <= '0;
            r_wr        <= '0;
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tcount    <= n_tcount;
            r_idx       <= n_idx;
            r_wr        <= n_wr;
            r_wptr      <= n_wptr;
            r_rptr      <= n_rptr;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_valid <= n_ev_valid;
        r_ev_pr    <= n_ev_pr;
        r_ev_key   <= n_ev_key;
    end

    // Next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_tcount    = r_tcount;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_wptr      = r_wptr;
        n_rptr      = r_rptr;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !i_ready;
        n_ev_valid  = r_ev_valid;
        n_ev_pr     = r_ev_pr;
        n_ev_key    = r_ev_key;
        t_we        = 1'b0;
        t_waddr     = r_wr[TW-1:0];
        t_wdata     = t_rdata;
        q_we        = 1'b0;
        q_wdata     = 9'h0;
        unique case (r_state)
            keq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_idx = '0;
                    n_wr  = '0;
                    n_state = (i_req_type == keq_pkg::REQ_CHAR) ?
                              keq_pkg::ST_SRCH_RD : keq_pkg::ST_EXP_RD;
                end
            end
            keq_pkg::ST_SRCH_RD: begin
                // Push the press event once, on entry
                if (r_idx == '0 && fifo_ok) begin
                    q_we    = 1'b1;
                    q_wdata = {1'b1, r_key};
                    n_wptr  = (r_wptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                    n_fill  = r_fill + 1'b1;
                end
                n_state = (r_idx < r_tcount) ? keq_pkg::ST_SRCH_CHK : keq_pkg::ST_SCHED;
            end
            keq_pkg::ST_SRCH_CHK: begin
                if (t_rdata[39:32] == r_key) begin
                    n_state = keq_pkg::ST_SCHED;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = keq_pkg::ST_SRCH_RD;
                end
            end
            keq_pkg::ST_SCHED: begin
                // Rewrite the matched slot or append
                t_waddr = r_idx[TW-1:0];
                t_wdata = {r_key, r_time + {16'h0, r_delay}};
                if (r_idx < r_tcount) begin
                    t_we = 1'b1;
                end else if (r_tcount < SLOTS_C) begin
                    t_we     = 1'b1;
                    n_tcount = r_tcount + 1'b1;
                end
                n_state = keq_pkg::ST_IDLE;
            end
            keq_pkg::ST_EXP_RD: begin
                n_state = (r_idx < r_tcount) ? keq_pkg::ST_EXP_CHK : keq_pkg::ST_POP_RD;
            end
            keq_pkg::ST_EXP_CHK: begin
                // Drop expired timers, compact the survivors downward
                if (!diff[31]) begin
                    if (fifo_ok) begin
                        q_we    = 1'b1;
                        q_wdata = {1'b0, t_rdata[39:32]};
                        n_wptr  = (r_wptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
                        n_fill  = r_fill + 1'b1;
                    end
                end else begin
                    t_we = (r_wr != r_idx);
                    n_wr = r_wr + 1'b1;
                end
                n_idx   = r_idx + 1'b1;
                n_state = keq_pkg::ST_EXP_RD;
            end
            keq_pkg::ST_POP_RD: begin
                n_tcount = r_wr;
                n_state  = keq_pkg::ST_POP_WAIT;
            end
            keq_pkg::ST_POP_WAIT: begin
                // Hold the pop while the previous result is still waiting
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    if (r_fill != '0) begin
                        n_ev_valid = 1'b1;
                        n_ev_pr    = q_rdata[8];
                        n_ev_key   = q_rdata[7:0];
                        n_rptr = (r_rptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
                        n_fill = r_fill - 1'b1;
                    end else begin
                        n_ev_valid = 1'b0;
                        n_ev_pr    = 1'b0;
                        n_ev_key   = 8'h0;
                    end
                    n_state = keq_pkg::ST_IDLE;
                end
            end
            default: n_state = keq_pkg::ST_IDLE;
        endcase
    end

    // Drive handshake outputs
    always_comb begin
        o_ready         = (r_state == keq_pkg::ST_IDLE);
        o_valid         = r_out_valid;
        o_event_valid   = r_ev_valid;
        o_event_pressed = r_ev_pr;
        o_event_key     = r_ev_key;
    end

endmodule
